### design/aps_pkg.sv
// Shared types and constants for the aging priority scheduler.
package aps_pkg;

	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int PRIO_W    = 8;
	localparam int BURST_W   = 16;
	localparam int TMR_W     = 2;
	localparam int WAIT_W    = 24;
	localparam int TAT_W     = 25;
	localparam int CLK_W     = 32;

	localparam logic [WAIT_W-1:0] WAIT_MAX   = {WAIT_W{1'b1}};
	localparam logic [TMR_W-1:0]  TMR_START  = 2'd2;
	localparam logic [TMR_W-1:0]  TMR_RELOAD = 2'd1;

	typedef enum logic [1:0] {
		KIND_ADMIT = 2'd0,
		KIND_TICK  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic admit;
		logic scan_step;
		logic decide;
		logic upd_step;
		logic finish_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic idx_end;
	} sts_t;

endpackage

### design/aps_ctrl.sv
// Controller state machine for the aging priority scheduler.
module aps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    kind,
	input  logic          out_stall,
	input  aps_pkg::sts_t sts,
	output aps_pkg::cmd_t cmd,
	output logic          in_stall,
	output logic          out_valid
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADMIT,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load_in     = in_valid;
			ST_ADMIT:  cmd.admit       = 1'b1;
			ST_SCAN:   cmd.scan_step   = !sts.idx_end;
			ST_DECIDE: cmd.decide      = 1'b1;
			ST_UPDATE: cmd.upd_step    = !sts.idx_end;
			ST_FINISH: cmd.finish_load = out_free;
			default:   cmd = '0;
		endcase
	end

	// Advance the sequencer and track the output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (aps_pkg::kind_t'(kind))
							aps_pkg::KIND_ADMIT: state_q <= ST_ADMIT;
							aps_pkg::KIND_TICK:  state_q <= ST_SCAN;
							default:             state_q <= ST_FINISH;
						endcase
					end
				end
				ST_ADMIT:  state_q <= ST_FINISH;
				ST_SCAN: begin
					if (sts.idx_end) state_q <= ST_DECIDE;
				end
				ST_DECIDE: state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (sts.idx_end) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/aps_dpath.sv
// Datapath for the aging priority scheduler: slot table, scan, update, result.
module aps_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  aps_pkg::cmd_t                 cmd,
	output aps_pkg::sts_t                 sts,
	input  logic [1:0]                    kind,
	input  logic [aps_pkg::PRIO_W-1:0]    priority_req,
	input  logic [aps_pkg::BURST_W-1:0]   burst,
	input  logic [aps_pkg::IDX_W-1:0]     slot,
	output logic                          status,
	output logic [aps_pkg::IDX_W-1:0]     chosen_slot,
	output logic                          chosen_valid,
	output logic                          switched,
	output logic [aps_pkg::CNT_W-1:0]     done_count,
	output logic [aps_pkg::CLK_W-1:0]     clock_now,
	output logic [aps_pkg::WAIT_W-1:0]    wait_time,
	output logic [aps_pkg::TAT_W-1:0]     turnaround
);

	// Slot table
	logic [aps_pkg::PRIO_W-1:0]  prio_q   [aps_pkg::MAX_PROCS];
	logic [aps_pkg::BURST_W-1:0] rem_q    [aps_pkg::MAX_PROCS];
	logic [aps_pkg::BURST_W-1:0] orig_q   [aps_pkg::MAX_PROCS];
	logic [aps_pkg::TMR_W-1:0]   tmr_q    [aps_pkg::MAX_PROCS];
	logic [aps_pkg::WAIT_W-1:0]  wait_q   [aps_pkg::MAX_PROCS];

	// Latched item
	logic [1:0]                  kind_q;
	logic [aps_pkg::PRIO_W-1:0]  prio_in_q;
	logic [aps_pkg::BURST_W-1:0] burst_in_q;
	logic [aps_pkg::IDX_W-1:0]   slot_in_q;

	// Scheduler control state
	logic [aps_pkg::CNT_W-1:0]   cnt_q;
	logic [aps_pkg::CNT_W-1:0]   done_q;
	logic [aps_pkg::CLK_W-1:0]   clock_q;
	logic [aps_pkg::IDX_W-1:0]   run_slot_q;
	logic                        run_valid_q;
	logic [aps_pkg::CNT_W-1:0]   idx_q;

	// Scan results
	logic                        found_q;
	logic [aps_pkg::IDX_W-1:0]   best_q;
	logic [aps_pkg::PRIO_W-1:0]  best_prio_q;
	logic [aps_pkg::BURST_W-1:0] best_rem_q;

	// Per-item result fields
	logic                        res_status_q;
	logic [aps_pkg::IDX_W-1:0]   res_chosen_q;
	logic                        res_cvalid_q;
	logic                        res_sw_q;

	// Output register
	logic                        status_q;
	logic [aps_pkg::IDX_W-1:0]   chosen_slot_q;
	logic                        chosen_valid_q;
	logic                        switched_q;
	logic [aps_pkg::CNT_W-1:0]   done_count_q;
	logic [aps_pkg::CLK_W-1:0]   clock_now_q;
	logic [aps_pkg::WAIT_W-1:0]  wait_time_q;
	logic [aps_pkg::TAT_W-1:0]   turnaround_q;

	logic [aps_pkg::IDX_W-1:0]   rd_idx;
	logic [aps_pkg::IDX_W-1:0]   cur_idx;
	logic [aps_pkg::PRIO_W-1:0]  rd_prio;
	logic [aps_pkg::BURST_W-1:0] rd_rem;
	logic [aps_pkg::BURST_W-1:0] rd_orig;
	logic [aps_pkg::TMR_W-1:0]   rd_tmr;
	logic [aps_pkg::WAIT_W-1:0]  rd_wait;
	logic                        is_run;
	logic [1:0]                  idle_steps;
	logic [aps_pkg::WAIT_W:0]    wait_sum;
	logic [aps_pkg::WAIT_W-1:0]  new_wait;
	logic [aps_pkg::PRIO_W-1:0]  new_prio;
	logic [aps_pkg::TMR_W-1:0]   new_tmr;
	logic                        tick_sw;
	logic                        table_full;
	logic                        query_hit;

	// Apply a few idle steps of aging to one slot
	function automatic logic [aps_pkg::PRIO_W+aps_pkg::TMR_W-1:0] age_f(
		input logic [aps_pkg::PRIO_W-1:0] p,
		input logic [aps_pkg::TMR_W-1:0]  t,
		input logic [1:0]                 k
	);
		logic [aps_pkg::PRIO_W-1:0] pv;
		logic [aps_pkg::TMR_W-1:0]  tv;
		pv = p;
		tv = t;
		for (int n = 0; n < 3; n++) begin
			if (2'(n) < k) begin
				if (tv != '0) begin
					tv = tv - 1'b1;
				end else begin
					tv = aps_pkg::TMR_RELOAD;
					if (pv != '0) pv = pv - 1'b1;
				end
			end
		end
		return {pv, tv};
	endfunction

	// Select the table entry to read
	assign cur_idx = idx_q[aps_pkg::IDX_W-1:0];
	assign rd_idx  = cmd.finish_load ? slot_in_q : cur_idx;
	assign rd_prio = prio_q[rd_idx];
	assign rd_rem  = rem_q[rd_idx];
	assign rd_orig = orig_q[rd_idx];
	assign rd_tmr  = tmr_q[rd_idx];
	assign rd_wait = wait_q[rd_idx];

	assign sts.idx_end = (idx_q == cnt_q);
	assign table_full  = (cnt_q == aps_pkg::CNT_W'(aps_pkg::MAX_PROCS));
	assign tick_sw     = run_valid_q && (!found_q || best_q != run_slot_q);
	assign query_hit   = (aps_pkg::kind_t'(kind_q) == aps_pkg::KIND_QUERY)
		&& ({1'b0, slot_in_q} < cnt_q);

	// Work out the new values of one slot for this tick
	always_comb begin
		is_run = found_q && (cur_idx == best_q);
		if (is_run) begin
			idle_steps = res_sw_q ? 2'd2 : 2'd0;
		end else begin
			idle_steps = res_sw_q ? 2'd3 : 2'd1;
		end
		wait_sum = {1'b0, rd_wait} + {{(aps_pkg::WAIT_W-1){1'b0}}, idle_steps};
		new_wait = (wait_sum > {1'b0, aps_pkg::WAIT_MAX}) ? aps_pkg::WAIT_MAX
			: wait_sum[aps_pkg::WAIT_W-1:0];
		{new_prio, new_tmr} = age_f(rd_prio, rd_tmr, idle_steps);
	end

	// Write the slot table
	always_ff @(posedge clk) begin
		if (cmd.admit && !table_full) begin
			prio_q[cnt_q[aps_pkg::IDX_W-1:0]] <= prio_in_q;
			rem_q[cnt_q[aps_pkg::IDX_W-1:0]]  <= burst_in_q;
			orig_q[cnt_q[aps_pkg::IDX_W-1:0]] <= burst_in_q;
			tmr_q[cnt_q[aps_pkg::IDX_W-1:0]]  <= aps_pkg::TMR_START;
			wait_q[cnt_q[aps_pkg::IDX_W-1:0]] <= '0;
		end else if (cmd.upd_step && rd_rem != '0) begin
			prio_q[cur_idx] <= new_prio;
			tmr_q[cur_idx]  <= new_tmr;
			wait_q[cur_idx] <= new_wait;
			if (is_run) rem_q[cur_idx] <= rd_rem - 1'b1;
		end
	end

	// Hold the item and the per-item scan and result fields
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q       <= kind;
			prio_in_q    <= priority_req;
			burst_in_q   <= burst;
			slot_in_q    <= slot;
			res_status_q <= 1'b0;
			res_chosen_q <= '0;
			res_cvalid_q <= 1'b0;
			res_sw_q     <= 1'b0;
		end
		if (cmd.admit) res_status_q <= table_full;
		if (cmd.scan_step && rd_rem != '0 && (!found_q || rd_prio < best_prio_q)) begin
			best_q      <= cur_idx;
			best_prio_q <= rd_prio;
			best_rem_q  <= rd_rem;
		end
		if (cmd.decide) begin
			res_sw_q     <= tick_sw;
			res_cvalid_q <= found_q;
			res_chosen_q <= found_q ? best_q : '0;
		end
		if (cmd.finish_load) begin
			status_q       <= res_status_q;
			chosen_slot_q  <= res_chosen_q;
			chosen_valid_q <= res_cvalid_q;
			switched_q     <= res_sw_q;
			done_count_q   <= done_q;
			clock_now_q    <= clock_q;
			wait_time_q    <= query_hit ? rd_wait : '0;
			turnaround_q   <= query_hit
				? ({{(aps_pkg::TAT_W-aps_pkg::BURST_W){1'b0}}, rd_orig}
					+ {1'b0, rd_wait})
				: '0;
		end
	end

	// Advance counters, clock and running slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			done_q      <= '0;
			clock_q     <= '0;
			run_slot_q  <= '0;
			run_valid_q <= 1'b0;
			idx_q       <= '0;
			found_q     <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (cmd.admit && !table_full) begin
				cnt_q <= cnt_q + 1'b1;
				if (burst_in_q == '0) done_q <= done_q + 1'b1;
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (rd_rem != '0 && (!found_q || rd_prio < best_prio_q)) found_q <= 1'b1;
			end
			if (cmd.decide) begin
				idx_q       <= '0;
				clock_q     <= clock_q + (tick_sw ? 32'd2 : 32'd1);
				run_valid_q <= found_q;
				run_slot_q  <= found_q ? best_q : '0;
				if (found_q && best_rem_q == 16'd1) done_q <= done_q + 1'b1;
			end
			if (cmd.upd_step) idx_q <= idx_q + 1'b1;
		end
	end

	assign status       = status_q;
	assign chosen_slot  = chosen_slot_q;
	assign chosen_valid = chosen_valid_q;
	assign switched     = switched_q;
	assign done_count   = done_count_q;
	assign clock_now    = clock_now_q;
	assign wait_time    = wait_time_q;
	assign turnaround   = turnaround_q;

endmodule

### design/aging_priority_scheduler.sv
// Top level of the preemptive priority scheduler with aging.
//
// Input channel (in_valid / in_stall) carries one item per beat: kind selects
// admit, tick, query or no-op; priority_req and burst describe an admitted
// process, slot names the slot a query asks about. Output channel
// (out_valid / out_stall) returns exactly one result beat per item.
// Items are worked one at a time. From IDLE, an admit passes through ADMIT and
// FINISH, a query or no-op goes straight to FINISH, and a tick passes through
// SCAN, DECIDE, UPDATE and FINISH: a tick walks the
// slot table once to pick the slot to run and once more to charge wait,
// aging and burst, one slot per cycle through a single table read port.
// in_stall is high from the accepting edge until the result is registered;
// a new item may be taken while that result still waits at the output.
// If the receiver stalls, the finished result holds in the output register and
// the next item waits in its last cycle until that beat is taken.
// Reset clears the slot count, done count, elapsed clock and running slot and
// empties the output; slot contents are written only on admit and tick.
module aging_priority_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    kind,
	input  logic [aps_pkg::PRIO_W-1:0]    priority_req,
	input  logic [aps_pkg::BURST_W-1:0]   burst,
	input  logic [aps_pkg::IDX_W-1:0]     slot,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          status,
	output logic [aps_pkg::IDX_W-1:0]     chosen_slot,
	output logic                          chosen_valid,
	output logic                          switched,
	output logic [aps_pkg::CNT_W-1:0]     done_count,
	output logic [aps_pkg::CLK_W-1:0]     clock_now,
	output logic [aps_pkg::WAIT_W-1:0]    wait_time,
	output logic [aps_pkg::TAT_W-1:0]     turnaround
);

	aps_pkg::cmd_t cmd;
	aps_pkg::sts_t sts;

	aps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	aps_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.priority_req (priority_req),
		.burst        (burst),
		.slot         (slot),
		.status       (status),
		.chosen_slot  (chosen_slot),
		.chosen_valid (chosen_valid),
		.switched     (switched),
		.done_count   (done_count),
		.clock_now    (clock_now),
		.wait_time    (wait_time),
		.turnaround   (turnaround)
	);

endmodule

### design/aps_checker.sv
// Port-level checks for the aging priority scheduler, bound to the top level.
module aps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          status,
	input logic [aps_pkg::IDX_W-1:0]     chosen_slot,
	input logic                          chosen_valid,
	input logic                          switched,
	input logic [aps_pkg::WAIT_W-1:0]    wait_time,
	input logic [aps_pkg::TAT_W-1:0]     turnaround
);

	// A stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// An accepted item keeps the input side busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	// No chosen slot without a valid choice
	a_chosen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !chosen_valid |-> chosen_slot == '0)
		else $error("chosen slot set without a valid choice");

	// A full-table admit reports nothing else
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !chosen_valid && !switched && wait_time == '0)
		else $error("full-table result carries tick or query fields");

	// Turnaround never falls below the wait it includes
	a_tat_ge_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> turnaround >= {1'b0, wait_time})
		else $error("turnaround below wait");

endmodule

bind aging_priority_scheduler aps_checker u_aps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.chosen_slot  (chosen_slot),
	.chosen_valid (chosen_valid),
	.switched     (switched),
	.wait_time    (wait_time),
	.turnaround   (turnaround)
);

### tb/sv/aging_priority_scheduler_tb.sv
// Self-checking testbench for aging_priority_scheduler: directed and random beats against a predictor.
module aging_priority_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import aps_pkg::*;

	localparam int RANDOM_OPS   = 1080;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_LEN     = 400;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		kind_t               kind;
		logic [PRIO_W-1:0]   priority_req;
		logic [BURST_W-1:0]  burst;
		logic [IDX_W-1:0]    slot;
	} sched_op_t;

	typedef struct packed {
		logic                status;
		logic [IDX_W-1:0]    chosen_slot;
		logic                chosen_valid;
		logic                switched;
		logic [CNT_W-1:0]    done_count;
		logic [CLK_W-1:0]    clock_now;
		logic [WAIT_W-1:0]   wait_time;
		logic [TAT_W-1:0]    turnaround;
	} sched_result_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [1:0]          kind         = '0;
	logic [PRIO_W-1:0]   priority_req = '0;
	logic [BURST_W-1:0]  burst        = '0;
	logic [IDX_W-1:0]    slot         = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic                status;
	logic [IDX_W-1:0]    chosen_slot;
	logic                chosen_valid;
	logic                switched;
	logic [CNT_W-1:0]    done_count;
	logic [CLK_W-1:0]    clock_now;
	logic [WAIT_W-1:0]   wait_time;
	logic [TAT_W-1:0]    turnaround;

	aging_priority_scheduler i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.priority_req (priority_req),
		.burst        (burst),
		.slot         (slot),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.chosen_slot  (chosen_slot),
		.chosen_valid (chosen_valid),
		.switched     (switched),
		.done_count   (done_count),
		.clock_now    (clock_now),
		.wait_time    (wait_time),
		.turnaround   (turnaround)
	);

	// Process table as the scheduler should hold it
	logic [PRIO_W-1:0]   tbl_prio  [MAX_PROCS];
	logic [BURST_W-1:0]  tbl_left  [MAX_PROCS];
	logic [BURST_W-1:0]  tbl_burst [MAX_PROCS];
	logic [TMR_W-1:0]    tbl_age   [MAX_PROCS];
	logic [WAIT_W-1:0]   tbl_wait  [MAX_PROCS];
	int                  tbl_count   = 0;
	int                  run_slot    = 0;
	bit                  run_valid   = 1'b0;
	logic [CLK_W-1:0]    elapsed     = '0;

	sched_op_t           sched_ops[$];
	sched_result_t       due_results[$];
	sched_op_t           cur_op      = '0;
	int                  ops_total   = 0;
	int                  ops_taken   = 0;
	int                  results_seen = 0;
	int                  mismatches  = 0;
	int                  gen_admitted = 0;
	int                  gap_left    = 0;
	int                  stall_left  = 0;
	int                  hold_left   = 0;
	bit                  hold_done   = 1'b0;
	int                  quiet_cycles = 0;

	// One time unit: waiting slots gain wait and age, the running slot burns burst
	function automatic void advance_unit(bit run, int who);
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_left[i] != '0) begin
				if (run && i == who) begin
					tbl_left[i] = tbl_left[i] - 1'b1;
				end else begin
					if (tbl_wait[i] != WAIT_MAX)
						tbl_wait[i] = tbl_wait[i] + 1'b1;
					if (tbl_age[i] != '0) begin
						tbl_age[i] = tbl_age[i] - 1'b1;
					end else begin
						tbl_age[i] = TMR_RELOAD;
						if (tbl_prio[i] != '0)
							tbl_prio[i] = tbl_prio[i] - 1'b1;
					end
				end
			end
		end
	endfunction

	// Apply one beat to the table and return the result it should produce
	function automatic sched_result_t schedule_op(sched_op_t op);
		sched_result_t r;
		int best;
		bit found;
		int finished;
		r = '0;
		best = 0;
		found = 1'b0;
		finished = 0;
		case (op.kind)
			KIND_ADMIT: begin
				if (tbl_count >= MAX_PROCS) begin
					r.status = 1'b1;
				end else begin
					tbl_prio[tbl_count]  = op.priority_req;
					tbl_left[tbl_count]  = op.burst;
					tbl_burst[tbl_count] = op.burst;
					tbl_age[tbl_count]   = TMR_START;
					tbl_wait[tbl_count]  = '0;
					tbl_count++;
				end
			end
			KIND_TICK: begin
				// pick lowest priority value, ties to lowest index
				for (int i = 0; i < tbl_count; i++)
					if (tbl_left[i] != '0 && (!found || tbl_prio[i] < tbl_prio[best])) begin
						best = i;
						found = 1'b1;
					end
				if (!run_valid || (found && best == run_slot)) begin
					elapsed = elapsed + 1;
					advance_unit(found, best);
				end else begin
					// pay the switch: two idle units, then the run unit
					elapsed = elapsed + 2;
					advance_unit(1'b0, 0);
					advance_unit(1'b0, 0);
					advance_unit(found, best);
					r.switched = 1'b1;
				end
				run_valid = found;
				run_slot = found ? best : 0;
				r.chosen_slot = found ? IDX_W'(best) : '0;
				r.chosen_valid = found;
			end
			KIND_QUERY: begin
				if (int'(op.slot) < tbl_count) begin
					r.wait_time = tbl_wait[op.slot];
					r.turnaround = TAT_W'(tbl_burst[op.slot]) + TAT_W'(tbl_wait[op.slot]);
				end
			end
			default: ;
		endcase
		for (int i = 0; i < tbl_count; i++)
			if (tbl_left[i] == '0)
				finished++;
		r.done_count = CNT_W'(finished);
		r.clock_now = elapsed;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	task automatic add_op(kind_t k, int p, int b, int s);
		sched_op_t op;
		op.kind = k;
		op.priority_req = PRIO_W'(p);
		op.burst = BURST_W'(b);
		op.slot = IDX_W'(s);
		sched_ops.push_back(op);
		if (k == KIND_ADMIT && gen_admitted < MAX_PROCS)
			gen_admitted++;
	endtask

	task automatic flag_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
		$display("mismatch on %s at beat %0d: got %0h, expected %0h",
			what, results_seen, seen, wanted);
		mismatches++;
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	// Drive input beats from the queue, holding each while stalled
	always @(posedge clk or negedge arst_n) begin : feed_ops
		sched_op_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				due_results.push_back(schedule_op(cur_op));
				ops_taken <= ops_taken + 1;
			end
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (sched_ops.size() != 0) begin
				nxt = sched_ops.pop_front();
				cur_op       <= nxt;
				kind         <= nxt.kind;
				priority_req <= nxt.priority_req;
				burst        <= nxt.burst;
				slot         <= nxt.slot;
				in_valid     <= 1'b1;
				gap_left     <= ((ops_taken % 250) < 50) ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the output at random, with one long hold-off to back up the input
	always @(posedge clk or negedge arst_n) begin : drive_out_stall
		int n;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
			hold_done  <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN - 1;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			n = ((results_seen % 250) >= 120 && (results_seen % 250) < 170)
				|| $urandom_range(0, 2) != 0 ? 0 : pick_gap();
			out_stall  <= (n != 0);
			stall_left <= (n != 0) ? n - 1 : 0;
		end
	end

	// Compare each output beat with the oldest expectation
	always @(posedge clk or negedge arst_n) begin : check_results
		sched_result_t want;
		if (!arst_n) begin
			results_seen <= 0;
		end else if (out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (due_results.size() == 0) begin
				flag_mismatch("unexpected beat", '0, '0);
			end else begin
				want = due_results.pop_front();
				if (status !== want.status)
					flag_mismatch("status", status, want.status);
				if (chosen_slot !== want.chosen_slot)
					flag_mismatch("chosen_slot", chosen_slot, want.chosen_slot);
				if (chosen_valid !== want.chosen_valid)
					flag_mismatch("chosen_valid", chosen_valid, want.chosen_valid);
				if (switched !== want.switched)
					flag_mismatch("switched", switched, want.switched);
				if (done_count !== want.done_count)
					flag_mismatch("done_count", done_count, want.done_count);
				if (clock_now !== want.clock_now)
					flag_mismatch("clock_now", clock_now, want.clock_now);
				if (wait_time !== want.wait_time)
					flag_mismatch("wait_time", wait_time, want.wait_time);
				if (turnaround !== want.turnaround)
					flag_mismatch("turnaround", turnaround, want.turnaround);
			end
		end
	end

	// Abort when no beat moves on either side for too long
	always @(posedge clk or negedge arst_n) begin : watchdog
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("aging_priority_scheduler_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : run_test
		int r;
		int p;
		int b;
		int q;

		// Directed: empty table, zero burst, preemption, idle-out, priority tie
		add_op(KIND_TICK, 8'hFF, 16'hFFFF, 4'hF);
		add_op(KIND_NOP, $urandom, $urandom, $urandom);
		add_op(KIND_ADMIT, 255, 2, 0);
		add_op(KIND_ADMIT, 0, 0, 4'hF);
		add_op(KIND_QUERY, 0, 0, 0);
		add_op(KIND_QUERY, 8'hFF, 16'hFFFF, 1);
		add_op(KIND_TICK, 0, 0, 0);
		add_op(KIND_ADMIT, 3, 3, 0);
		repeat (6)
			add_op(KIND_TICK, $urandom, $urandom, $urandom);
		add_op(KIND_QUERY, $urandom, $urandom, 2);
		add_op(KIND_QUERY, $urandom, $urandom, 0);
		add_op(KIND_ADMIT, 50, 2, $urandom);
		add_op(KIND_ADMIT, 50, 2, $urandom);
		repeat (3)
			add_op(KIND_TICK, $urandom, $urandom, $urandom);
		add_op(KIND_NOP, 0, 0, 0);
		add_op(KIND_QUERY, $urandom, $urandom, 3);

		// Random: mostly ticks and queries, with admits of mostly short jobs that fill the table
		for (int n = 0; n < RANDOM_OPS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				q = $urandom_range(0, 9);
				if (gen_admitted == MAX_PROCS)
					b = $urandom;
				else if (gen_admitted == MAX_PROCS - 1)
					b = 16'hFFFF;
				else if (q == 0)
					b = 0;
				else if (q < 9)
					b = $urandom_range(1, 24);
				else
					b = $urandom_range(25, 160);
				if ($urandom_range(0, 7) == 0)
					p = $urandom_range(0, 1) ? 255 : 0;
				else
					p = $urandom_range(0, 255);
				add_op(KIND_ADMIT, p, b, $urandom);
			end else if (r < 62 || (r < 85 && gen_admitted == 0)) begin
				add_op(KIND_TICK, $urandom, $urandom, $urandom);
			end else if (r < 85) begin
				add_op(KIND_QUERY, $urandom, $urandom, $urandom_range(0, gen_admitted - 1));
			end else begin
				add_op(KIND_NOP, $urandom, $urandom, $urandom);
			end
		end
		ops_total = sched_ops.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_taken != ops_total)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && due_results.size() == 0)
			$display("aging_priority_scheduler_tb OK");
		else
			$display("aging_priority_scheduler_tb NOT OK");
		$finish;
	end

endmodule

### filelist.f
design/aps_pkg.sv
design/aps_ctrl.sv
design/aps_dpath.sv
design/aging_priority_scheduler.sv
design/aps_checker.sv
tb/sv/aging_priority_scheduler_tb.sv
